>>> src/msp_pkg.sv
// Package for the MSP frame decoder: parser states, frame character codes
// and the byte-wide CRC-8 (poly 0xD5) update. No dependencies.
package msp_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VERSION,
    ST_DIR_V1,
    ST_DIR_V2,
    ST_FLAG_V2,
    ST_LEN_V1,
    ST_CODE_V1,
    ST_CODE_JUMBO,
    ST_JLEN_LO,
    ST_JLEN_HI,
    ST_PAY_V1,
    ST_CHK_V1,
    ST_CODE_V2_LO,
    ST_CODE_V2_HI,
    ST_LEN_V2_LO,
    ST_LEN_V2_HI,
    ST_PAY_V2,
    ST_CHK_V2
  } parse_state_e;

  localparam logic [7:0] ChSync    = 8'h24;  // '$'
  localparam logic [7:0] ChVerV1   = 8'h4D;  // 'M'
  localparam logic [7:0] ChVerV2   = 8'h58;  // 'X'
  localparam logic [7:0] ChDirOut  = 8'h3E;  // '>'
  localparam logic [7:0] ChDirIn   = 8'h3C;  // '<'
  localparam logic [7:0] ChDirErr  = 8'h21;  // '!'
  localparam logic [7:0] JumboLen  = 8'hFF;
  localparam logic [7:0] CrcPoly   = 8'hD5;
  localparam logic [15:0] MaxLenReset = 16'd4096;

  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CrcPoly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

>>> src/msp_frame_decoder.sv
// MSP v1 / jumbo / v2 frame decoder: one received byte per item in, payload
// bytes and frame-end items out. Depends on msp_pkg.
//
//   channel   signals                                   direction
//   in        in_valid_i, in_ready_o, rx_byte_i         in
//   out       out_valid_o, out_ready_i, item_kind_o ..  out
//   cfg       cfg_we_i, cfg_data_i (max_payload_len)    in
//
// One item per cycle unless the output stalls: the parser state and the
// result register both load at the accepting edge, so a result appears in the
// cycle after its byte. Bytes outside payload and checksum produce no result.
// The input is ready whenever the result register is empty or being taken.
// Reset returns the parser to idle and sets max_payload_len to 4096.
module msp_frame_decoder
  import msp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] msg_code_o,
  output logic [15:0] payload_len_o,
  output logic        checksum_ok_o,
  output logic        from_device_o,
  output logic        unsupported_o,
  output logic        is_v2_o
);

  parse_state_e state_q, state_d;
  logic [15:0] code_q, code_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  crc_q, crc_d;
  logic        dir_q, dir_d;
  logic        unsup_q, unsup_d;
  logic [15:0] max_len_q;

  logic        in_fire;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data;
  logic        res_ok;
  logic        res_v2;
  logic [15:0] count_inc;

  logic        out_valid_q;
  logic        kind_q;
  logic [7:0]  data_q;
  logic [15:0] code_out_q;
  logic [15:0] len_out_q;
  logic        ok_q;
  logic        dir_out_q;
  logic        unsup_out_q;
  logic        v2_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_inc  = count_q + 16'd1;

  always_comb begin
    state_d   = state_q;
    code_d    = code_q;
    len_d     = len_q;
    count_d   = count_q;
    xor_d     = xor_q;
    crc_d     = crc_q;
    dir_d     = dir_q;
    unsup_d   = unsup_q;
    res_valid = 1'b0;
    res_kind  = KindPayload;
    res_data  = 8'd0;
    res_ok    = 1'b0;
    res_v2    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (rx_byte_i == ChSync) state_d = ST_VERSION;
      end
      ST_VERSION: begin
        xor_d = 8'd0;
        crc_d = 8'd0;
        if (rx_byte_i == ChVerV1)      state_d = ST_DIR_V1;
        else if (rx_byte_i == ChVerV2) state_d = ST_DIR_V2;
        else                           state_d = ST_IDLE;
      end
      ST_DIR_V1, ST_DIR_V2: begin
        unsup_d = 1'b0;
        if (rx_byte_i == ChDirOut)      dir_d = 1'b1;
        else if (rx_byte_i == ChDirIn)  dir_d = 1'b0;
        else if (rx_byte_i == ChDirErr) unsup_d = 1'b1;
        state_d = (state_q == ST_DIR_V1) ? ST_LEN_V1 : ST_FLAG_V2;
      end
      ST_FLAG_V2: begin
        crc_d   = crc8_step(crc_q, 8'd0);
        state_d = ST_CODE_V2_LO;
      end
      ST_LEN_V1: begin
        len_d   = {8'd0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        count_d = 16'd0;
        state_d = (rx_byte_i == JumboLen) ? ST_CODE_JUMBO : ST_CODE_V1;
      end
      ST_CODE_V1: begin
        code_d  = {8'd0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        state_d = (len_q != 16'd0) ? ST_PAY_V1 : ST_CHK_V1;
      end
      ST_CODE_JUMBO: begin
        code_d  = {8'd0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        state_d = ST_JLEN_LO;
      end
      ST_JLEN_LO: begin
        len_d   = {8'd0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        state_d = ST_JLEN_HI;
      end
      ST_JLEN_HI: begin
        len_d   = {rx_byte_i, len_q[7:0]};
        xor_d   = xor_q ^ rx_byte_i;
        count_d = 16'd0;
        state_d = ST_PAY_V1;
      end
      ST_CODE_V2_LO: begin
        code_d  = {8'd0, rx_byte_i};
        crc_d   = crc8_step(crc_q, rx_byte_i);
        state_d = ST_CODE_V2_HI;
      end
      ST_CODE_V2_HI: begin
        code_d  = {rx_byte_i, code_q[7:0]};
        crc_d   = crc8_step(crc_q, rx_byte_i);
        state_d = ST_LEN_V2_LO;
      end
      ST_LEN_V2_LO: begin
        len_d   = {8'd0, rx_byte_i};
        crc_d   = crc8_step(crc_q, rx_byte_i);
        state_d = ST_LEN_V2_HI;
      end
      ST_LEN_V2_HI: begin
        len_d   = {rx_byte_i, len_q[7:0]};
        crc_d   = crc8_step(crc_q, rx_byte_i);
        count_d = 16'd0;
        if (len_d > max_len_q)     state_d = ST_IDLE;
        else if (len_d != 16'd0)   state_d = ST_PAY_V2;
        else                       state_d = ST_CHK_V2;
      end
      ST_PAY_V1: begin
        xor_d     = xor_q ^ rx_byte_i;
        count_d   = count_inc;
        if (count_inc >= len_q) state_d = ST_CHK_V1;
        res_valid = 1'b1;
        res_data  = rx_byte_i;
      end
      ST_PAY_V2: begin
        crc_d     = crc8_step(crc_q, rx_byte_i);
        count_d   = count_inc;
        if (count_inc >= len_q) state_d = ST_CHK_V2;
        res_valid = 1'b1;
        res_data  = rx_byte_i;
        res_v2    = 1'b1;
      end
      ST_CHK_V1: begin
        res_valid = 1'b1;
        res_kind  = KindFrameEnd;
        res_ok    = (xor_q == rx_byte_i);
        state_d   = ST_IDLE;
      end
      ST_CHK_V2: begin
        res_valid = 1'b1;
        res_kind  = KindFrameEnd;
        res_ok    = (crc_q == rx_byte_i);
        res_v2    = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      code_q  <= 16'd0;
      len_q   <= 16'd0;
      count_q <= 16'd0;
      xor_q   <= 8'd0;
      crc_q   <= 8'd0;
      dir_q   <= 1'b0;
      unsup_q <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
      code_q  <= code_d;
      len_q   <= len_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      crc_q   <= crc_d;
      dir_q   <= dir_d;
      unsup_q <= unsup_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q      <= res_kind;
      data_q      <= res_data;
      code_out_q  <= code_q;
      len_out_q   <= len_q;
      ok_q        <= res_ok;
      dir_out_q   <= dir_q;
      unsup_out_q <= unsup_q;
      v2_q        <= res_v2;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign data_byte_o   = data_q;
  assign msg_code_o    = code_out_q;
  assign payload_len_o = len_out_q;
  assign checksum_ok_o = ok_q;
  assign from_device_o = dir_out_q;
  assign unsupported_o = unsup_out_q;
  assign is_v2_o       = v2_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (state_q == ST_CHK_V1 || state_q == ST_CHK_V2))
      |=> (state_q == ST_IDLE && out_valid_q && kind_q == KindFrameEnd))
    else $error("frame end did not return to idle with a result");

  a_payload_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KindPayload) |-> !ok_q)
    else $error("payload item carries checksum flag");

  a_end_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KindFrameEnd) |-> (data_q == 8'd0))
    else $error("frame-end item carries data");

  a_v1_code_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !v2_q) |-> (code_out_q[15:8] == 8'd0))
    else $error("v1 item with wide message code");

endmodule
